>>> hw/rtl/cctp_pkg.sv
// shared constants and types for the circumcircle block
package cctp_pkg;

   localparam int COORD_BITS_DEF       = 10;
   localparam int RADIUS_FRAC_BITS_DEF = 4;
   localparam int QUEUE_DEPTH          = 4;
   localparam int CENTER_W             = 32;
   localparam int RADIUS_W             = 36;

   typedef struct packed {
      logic collinear;
      logic x_neg;
      logic y_neg;
   } flags_type;

endpackage

>>> hw/rtl/circumcircle_three_points.sv
// top level of the circumcircle block
// Takes three points per beat and returns one circle per beat, in order. The front pipeline
// accepts a beat every cycle unless stalled by a full queue, and hands it after four stages
// to a four-entry queue. The back end works one item at a time: the bit-serial centre
// dividers and square root run side by side, then the bit-serial radius divider runs on the
// root. Collinear triples bypass the loops.
module circumcircle_three_points #(
   parameter int COORD_BITS       = cctp_pkg::COORD_BITS_DEF,
   parameter int RADIUS_FRAC_BITS = cctp_pkg::RADIUS_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_first_x,
   input  logic [COORD_BITS-1:0] req_first_y,
   input  logic [COORD_BITS-1:0] req_second_x,
   input  logic [COORD_BITS-1:0] req_second_y,
   input  logic [COORD_BITS-1:0] req_third_x,
   input  logic [COORD_BITS-1:0] req_third_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [cctp_pkg::CENTER_W-1:0] rsp_center_x,
   output logic signed [cctp_pkg::CENTER_W-1:0] rsp_center_y,
   output logic [cctp_pkg::RADIUS_W-1:0]        rsp_radius_q4,
   output logic                  rsp_collinear,
   output logic                  rsp_clipped
);
   localparam int C   = COORD_BITS;
   localparam int AW  = 2 * C + 3;
   localparam int MW  = 3 * C + 4;
   localparam int OW  = 6 * C + 3 + 2 * RADIUS_FRAC_BITS;
   localparam int SOW = 2 * ((OW + 1) / 2);
   localparam int FW  = $bits(cctp_pkg::flags_type);
   localparam int QW  = FW + 2 * MW + AW + SOW;

   logic q_push, q_full, q_pop, q_valid;
   cctp_pkg::flags_type f_flags, b_flags;
   logic [MW-1:0]  f_nx, f_ny, b_nx, b_ny;
   logic [AW-1:0]  f_ad, b_ad;
   logic [SOW-1:0] f_op, b_op;
   logic [QW-1:0]  q_in, q_out;

   cctp_front #(
      .COORD_BITS(COORD_BITS),
      .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_x(req_first_x),
      .req_first_y(req_first_y),
      .req_second_x(req_second_x),
      .req_second_y(req_second_y),
      .req_third_x(req_third_x),
      .req_third_y(req_third_y),
      .q_push(q_push),
      .q_full(q_full),
      .q_flags(f_flags),
      .q_nx_mag(f_nx),
      .q_ny_mag(f_ny),
      .q_abs_d(f_ad),
      .q_operand(f_op)
   );

   assign q_in = {f_flags, f_nx, f_ny, f_ad, f_op};

   cctp_queue #(
      .WIDTH(QW),
      .DEPTH(cctp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_in),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .pop_data(q_out)
   );

   assign {b_flags, b_nx, b_ny, b_ad, b_op} = q_out;

   cctp_back #(
      .COORD_BITS(COORD_BITS),
      .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_flags(b_flags),
      .q_nx_mag(b_nx),
      .q_ny_mag(b_ny),
      .q_abs_d(b_ad),
      .q_operand(b_op),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_center_x(rsp_center_x),
      .rsp_center_y(rsp_center_y),
      .rsp_radius_q4(rsp_radius_q4),
      .rsp_collinear(rsp_collinear),
      .rsp_clipped(rsp_clipped)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   a_collinear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_collinear) |->
         (rsp_center_x == '0 && rsp_center_y == '0 && rsp_radius_q4 == '0 && !rsp_clipped))
      else $error("collinear beat carries a non-zero circle");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

>>> hw/rtl/cctp_front.sv
// front pipeline: point differences, determinant, numerators and radius product
module cctp_front #(
   parameter int COORD_BITS       = cctp_pkg::COORD_BITS_DEF,
   parameter int RADIUS_FRAC_BITS = cctp_pkg::RADIUS_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_first_x,
   input  logic [COORD_BITS-1:0] req_first_y,
   input  logic [COORD_BITS-1:0] req_second_x,
   input  logic [COORD_BITS-1:0] req_second_y,
   input  logic [COORD_BITS-1:0] req_third_x,
   input  logic [COORD_BITS-1:0] req_third_y,
   output logic                  q_push,
   input  logic                  q_full,
   output cctp_pkg::flags_type   q_flags,
   output logic [3*COORD_BITS+3:0] q_nx_mag,
   output logic [3*COORD_BITS+3:0] q_ny_mag,
   output logic [2*COORD_BITS+2:0] q_abs_d,
   output logic [2*(((6*COORD_BITS+3+2*RADIUS_FRAC_BITS)+1)/2)-1:0] q_operand
);
   localparam int C    = COORD_BITS;
   localparam int DW   = C + 1;
   localparam int NW   = 2 * C + 1;
   localparam int BW   = 2 * C + 2;
   localparam int PW   = 2 * C + 2;
   localparam int DTW  = 2 * C + 3;
   localparam int AW   = 2 * C + 3;
   localparam int SQW  = 2 * C + 1;
   localparam int SABW = 4 * C + 2;
   localparam int H    = 2 * C + 1;
   localparam int PPW  = H + SQW;
   localparam int TW   = 3 * C + 3;
   localparam int MW   = 3 * C + 4;
   localparam int PRW  = 6 * C + 3;
   localparam int OW   = PRW + 2 * RADIUS_FRAC_BITS;
   localparam int RW   = (OW + 1) / 2;
   localparam int SOW  = 2 * RW;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic mv1, mv2, mv3, mv4, acc;

   logic [C-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff, s1_x3_ff, s1_y3_ff;
   logic signed [DW-1:0] s1_dx12_ff, s1_dy12_ff, s1_dx23_ff, s1_dy23_ff;
   logic signed [DW-1:0] s1_dx31_ff, s1_dy31_ff;

   logic [NW-1:0] s2_n1_ff, s2_n2_ff, s2_n3_ff;
   logic signed [PW-1:0] s2_p1_ff, s2_p2_ff;
   logic [SQW-1:0] s2_sa_ff, s2_sb_ff, s2_sc_ff;
   logic signed [DW-1:0] s2_dx12_ff, s2_dy12_ff, s2_dx23_ff, s2_dy23_ff;

   logic signed [BW-1:0] s3_bb_ff, s3_cc_ff;
   logic signed [DTW-1:0] s3_det_ff;
   logic [SABW-1:0] s3_sab_ff;
   logic [SQW-1:0] s3_sc_ff;
   logic signed [DW-1:0] s3_dx12_ff, s3_dy12_ff, s3_dx23_ff, s3_dy23_ff;

   logic signed [TW-1:0] s4_t1_ff, s4_t2_ff, s4_t3_ff, s4_t4_ff;
   logic [PPW-1:0] s4_pl_ff, s4_ph_ff;
   logic s4_coll_ff, s4_dneg_ff;
   logic [AW-1:0] s4_ad_ff;

   logic signed [DTW-1:0] abs_det;
   logic signed [MW-1:0] nx, ny;
   logic [PRW-1:0] prod;

   assign mv4 = v4_ff && !q_full;
   assign mv3 = v3_ff && (!v4_ff || mv4);
   assign mv2 = v2_ff && (!v3_ff || mv3);
   assign mv1 = v1_ff && (!v2_ff || mv2);
   assign req_stall = v1_ff && !mv1;
   assign acc = req_valid && !req_stall;

   assign v1_in = acc ? 1'b1 : (mv1 ? 1'b0 : v1_ff);
   assign v2_in = mv1 ? 1'b1 : (mv2 ? 1'b0 : v2_ff);
   assign v3_in = mv2 ? 1'b1 : (mv3 ? 1'b0 : v3_ff);
   assign v4_in = mv3 ? 1'b1 : (mv4 ? 1'b0 : v4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // differences
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_x1_ff   <= req_first_x;
         s1_y1_ff   <= req_first_y;
         s1_x2_ff   <= req_second_x;
         s1_y2_ff   <= req_second_y;
         s1_x3_ff   <= req_third_x;
         s1_y3_ff   <= req_third_y;
         s1_dx12_ff <= $signed({1'b0, req_first_x}) - $signed({1'b0, req_second_x});
         s1_dy12_ff <= $signed({1'b0, req_first_y}) - $signed({1'b0, req_second_y});
         s1_dx23_ff <= $signed({1'b0, req_second_x}) - $signed({1'b0, req_third_x});
         s1_dy23_ff <= $signed({1'b0, req_second_y}) - $signed({1'b0, req_third_y});
         s1_dx31_ff <= $signed({1'b0, req_third_x}) - $signed({1'b0, req_first_x});
         s1_dy31_ff <= $signed({1'b0, req_third_y}) - $signed({1'b0, req_first_y});
      end
   end

   // squared norms and cross products
   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_n1_ff <= NW'(s1_x1_ff) * NW'(s1_x1_ff) + NW'(s1_y1_ff) * NW'(s1_y1_ff);
         s2_n2_ff <= NW'(s1_x2_ff) * NW'(s1_x2_ff) + NW'(s1_y2_ff) * NW'(s1_y2_ff);
         s2_n3_ff <= NW'(s1_x3_ff) * NW'(s1_x3_ff) + NW'(s1_y3_ff) * NW'(s1_y3_ff);
         s2_p1_ff <= PW'(s1_dx12_ff) * PW'(s1_dy23_ff);
         s2_p2_ff <= PW'(s1_dx23_ff) * PW'(s1_dy12_ff);
         s2_sa_ff <= SQW'($unsigned(PW'(s1_dx12_ff) * PW'(s1_dx12_ff)))
                   + SQW'($unsigned(PW'(s1_dy12_ff) * PW'(s1_dy12_ff)));
         s2_sb_ff <= SQW'($unsigned(PW'(s1_dx23_ff) * PW'(s1_dx23_ff)))
                   + SQW'($unsigned(PW'(s1_dy23_ff) * PW'(s1_dy23_ff)));
         s2_sc_ff <= SQW'($unsigned(PW'(s1_dx31_ff) * PW'(s1_dx31_ff)))
                   + SQW'($unsigned(PW'(s1_dy31_ff) * PW'(s1_dy31_ff)));
         s2_dx12_ff <= s1_dx12_ff;
         s2_dy12_ff <= s1_dy12_ff;
         s2_dx23_ff <= s1_dx23_ff;
         s2_dy23_ff <= s1_dy23_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv2) begin
         s3_bb_ff   <= $signed({1'b0, s2_n1_ff}) - $signed({1'b0, s2_n2_ff});
         s3_cc_ff   <= $signed({1'b0, s2_n2_ff}) - $signed({1'b0, s2_n3_ff});
         s3_det_ff  <= DTW'(s2_p1_ff) - DTW'(s2_p2_ff);
         s3_sab_ff  <= SABW'(s2_sa_ff) * SABW'(s2_sb_ff);
         s3_sc_ff   <= s2_sc_ff;
         s3_dx12_ff <= s2_dx12_ff;
         s3_dy12_ff <= s2_dy12_ff;
         s3_dx23_ff <= s2_dx23_ff;
         s3_dy23_ff <= s2_dy23_ff;
      end
   end

   assign abs_det = s3_det_ff[DTW-1] ? -s3_det_ff : s3_det_ff;

   always_ff @(posedge clock) begin
      if (mv3) begin
         s4_t1_ff   <= TW'(s3_bb_ff) * TW'(s3_dy23_ff);
         s4_t2_ff   <= TW'(s3_cc_ff) * TW'(s3_dy12_ff);
         s4_t3_ff   <= TW'(s3_cc_ff) * TW'(s3_dx12_ff);
         s4_t4_ff   <= TW'(s3_bb_ff) * TW'(s3_dx23_ff);
         s4_pl_ff   <= PPW'(s3_sab_ff[H-1:0]) * PPW'(s3_sc_ff);
         s4_ph_ff   <= PPW'(s3_sab_ff[SABW-1:H]) * PPW'(s3_sc_ff);
         s4_coll_ff <= (s3_det_ff == '0);
         s4_dneg_ff <= s3_det_ff[DTW-1];
         s4_ad_ff   <= {abs_det[AW-2:0], 1'b0};
      end
   end

   assign nx   = MW'(s4_t1_ff) - MW'(s4_t2_ff);
   assign ny   = MW'(s4_t3_ff) - MW'(s4_t4_ff);
   assign prod = (PRW'(s4_ph_ff) << H) + PRW'(s4_pl_ff);

   assign q_push            = mv4;
   assign q_flags.collinear = s4_coll_ff;
   assign q_flags.x_neg     = nx[MW-1] ^ s4_dneg_ff;
   assign q_flags.y_neg     = ny[MW-1] ^ s4_dneg_ff;
   assign q_nx_mag          = nx[MW-1] ? $unsigned(-nx) : $unsigned(nx);
   assign q_ny_mag          = ny[MW-1] ? $unsigned(-ny) : $unsigned(ny);
   assign q_abs_d           = s4_ad_ff;
   assign q_operand         = SOW'(prod) << (2 * RADIUS_FRAC_BITS);

endmodule

>>> hw/rtl/cctp_queue.sv
// small first-word-fall-through queue between front and back
module cctp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cctp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/cctp_back.sv
// back end: serial centre dividers, square root, radius divider and result register
module cctp_back #(
   parameter int COORD_BITS       = cctp_pkg::COORD_BITS_DEF,
   parameter int RADIUS_FRAC_BITS = cctp_pkg::RADIUS_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  cctp_pkg::flags_type   q_flags,
   input  logic [3*COORD_BITS+3:0] q_nx_mag,
   input  logic [3*COORD_BITS+3:0] q_ny_mag,
   input  logic [2*COORD_BITS+2:0] q_abs_d,
   input  logic [2*(((6*COORD_BITS+3+2*RADIUS_FRAC_BITS)+1)/2)-1:0] q_operand,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [cctp_pkg::CENTER_W-1:0] rsp_center_x,
   output logic signed [cctp_pkg::CENTER_W-1:0] rsp_center_y,
   output logic [cctp_pkg::RADIUS_W-1:0]        rsp_radius_q4,
   output logic                  rsp_collinear,
   output logic                  rsp_clipped
);
   localparam int C    = COORD_BITS;
   localparam int AW   = 2 * C + 3;
   localparam int MW   = 3 * C + 4;
   localparam int PRW  = 6 * C + 3;
   localparam int OW   = PRW + 2 * RADIUS_FRAC_BITS;
   localparam int RW   = (OW + 1) / 2;
   localparam int SOW  = 2 * RW;
   localparam int LMAX = (MW > RW) ? MW : RW;
   localparam int CNTW = $clog2(LMAX + 1);
   localparam int CW   = cctp_pkg::CENTER_W;
   localparam int RDW  = cctp_pkg::RADIUS_W;
   localparam int EXW  = (MW > CW + 1) ? MW : CW + 1;
   localparam int RXW  = (RW > RDW) ? RW : RDW;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ROOT = 4'b0010,
      ST_RDIV = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type state_ff;
   logic [CNTW-1:0] cnt_ff;
   cctp_pkg::flags_type flags_ff;
   logic [AW-1:0]  ad_ff;
   logic [MW-1:0]  dnx_ff, dny_ff;
   logic [AW-1:0]  xrem_ff, yrem_ff, rrem_ff;
   logic [SOW-1:0] opnd_ff;
   logic [RW+1:0]  srem_ff;
   logic [RW-1:0]  root_ff, rnum_ff;

   logic [AW:0]   xr2, yr2, rr2, dsor;
   logic          xge, yge, rge;
   logic [RW+2:0] sr2, strial;
   logic          sge, x_en, s_en;
   logic [RW-1:0] root_in;
   logic [RW+1:0] srem_in;
   logic          rsp_free;

   logic [EXW-1:0] qx, qy;
   logic [RXW-1:0] rx;
   logic signed [CW-1:0] cx, cy;
   logic [RDW-1:0] rad;
   logic xclip, yclip, rclip;

   logic rsp_valid_ff;
   logic signed [CW-1:0] rsp_cx_ff, rsp_cy_ff;
   logic [RDW-1:0] rsp_r_ff;
   logic rsp_coll_ff, rsp_clip_ff;

   assign dsor = {1'b0, ad_ff};
   assign xr2  = {xrem_ff, dnx_ff[MW-1]};
   assign yr2  = {yrem_ff, dny_ff[MW-1]};
   assign rr2  = {rrem_ff, rnum_ff[RW-1]};
   assign xge  = (xr2 >= dsor);
   assign yge  = (yr2 >= dsor);
   assign rge  = (rr2 >= dsor);

   assign sr2    = {srem_ff[RW:0], opnd_ff[SOW-1:SOW-2]};
   assign strial = (RW + 3)'({root_ff, 2'b01});
   assign sge    = (sr2 >= strial);
   assign x_en   = (cnt_ff < CNTW'(MW));
   assign s_en   = (cnt_ff < CNTW'(RW));
   assign root_in = s_en ? {root_ff[RW-2:0], sge} : root_ff;
   assign srem_in = sge ? (RW + 2)'(sr2 - strial) : (RW + 2)'(sr2);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   // quotients clamped (saturated) to the result range
   always_comb begin
      qx = EXW'(dnx_ff);
      qy = EXW'(dny_ff);
      rx = RXW'(rnum_ff);
      xclip = 1'b0;
      yclip = 1'b0;
      if (flags_ff.x_neg) begin
         xclip = (qx > EXW'(64'h8000_0000));
         cx = xclip ? $signed(32'h8000_0000) : $signed(-qx[CW-1:0]);
      end else begin
         xclip = (qx > EXW'(64'h7fff_ffff));
         cx = xclip ? $signed(32'h7fff_ffff) : $signed(qx[CW-1:0]);
      end
      if (flags_ff.y_neg) begin
         yclip = (qy > EXW'(64'h8000_0000));
         cy = yclip ? $signed(32'h8000_0000) : $signed(-qy[CW-1:0]);
      end else begin
         yclip = (qy > EXW'(64'h7fff_ffff));
         cy = yclip ? $signed(32'h7fff_ffff) : $signed(qy[CW-1:0]);
      end
      rclip = (rx > RXW'({RDW{1'b1}}));
      rad = rclip ? {RDW{1'b1}} : rx[RDW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cnt_ff   <= '0;
                  state_ff <= q_flags.collinear ? ST_HOLD : ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (cnt_ff == CNTW'(LMAX - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_RDIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_RDIV: begin
               if (cnt_ff == CNTW'(RW - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_HOLD;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_HOLD: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               flags_ff <= q_flags;
               ad_ff    <= q_abs_d;
               dnx_ff   <= q_nx_mag;
               dny_ff   <= q_ny_mag;
               xrem_ff  <= '0;
               yrem_ff  <= '0;
               opnd_ff  <= q_operand;
               srem_ff  <= '0;
               root_ff  <= '0;
            end
         end
         ST_ROOT: begin
            if (x_en) begin
               xrem_ff <= xge ? AW'(xr2 - dsor) : AW'(xr2);
               yrem_ff <= yge ? AW'(yr2 - dsor) : AW'(yr2);
               dnx_ff  <= {dnx_ff[MW-2:0], xge};
               dny_ff  <= {dny_ff[MW-2:0], yge};
            end
            if (s_en) begin
               srem_ff <= srem_in;
               opnd_ff <= {opnd_ff[SOW-3:0], 2'b00};
            end
            root_ff <= root_in;
            if (cnt_ff == CNTW'(LMAX - 1)) begin
               rnum_ff <= root_in;
               rrem_ff <= '0;
            end
         end
         ST_RDIV: begin
            rrem_ff <= rge ? AW'(rr2 - dsor) : AW'(rr2);
            rnum_ff <= {rnum_ff[RW-2:0], rge};
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_HOLD && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_HOLD && rsp_free) begin
         rsp_coll_ff <= flags_ff.collinear;
         if (flags_ff.collinear) begin
            rsp_cx_ff   <= '0;
            rsp_cy_ff   <= '0;
            rsp_r_ff    <= '0;
            rsp_clip_ff <= 1'b0;
         end else begin
            rsp_cx_ff   <= cx;
            rsp_cy_ff   <= cy;
            rsp_r_ff    <= rad;
            rsp_clip_ff <= xclip || yclip || rclip;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_center_x  = rsp_cx_ff;
   assign rsp_center_y  = rsp_cy_ff;
   assign rsp_radius_q4 = rsp_r_ff;
   assign rsp_collinear = rsp_coll_ff;
   assign rsp_clipped   = rsp_clip_ff;

endmodule

>>> test/testbench.sv
// testbench for the circumcircle block: random and directed triples checked against a predictor
`timescale 1ns / 100ps

module testbench;

   typedef struct {
      logic [9:0] x1, y1, x2, y2, x3, y3;
   } triple_type;

   typedef struct {
      logic signed [cctp_pkg::CENTER_W-1:0] cx, cy;
      logic [cctp_pkg::RADIUS_W-1:0]        rad;
      logic                                 col, clip;
   } circle_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [9:0] req_first_x = 0, req_first_y = 0, req_second_x = 0;
   logic [9:0] req_second_y = 0, req_third_x = 0, req_third_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [cctp_pkg::CENTER_W-1:0] rsp_center_x, rsp_center_y;
   logic [cctp_pkg::RADIUS_W-1:0] rsp_radius_q4;
   logic rsp_collinear, rsp_clipped;

   triple_type pending[$];
   circle_type expected_circles[$];
   int errors = 0;
   bit calm = 0;
   int idle_cycles = 0;
   int req_gap = 0, rsp_gap = 0;

   circumcircle_three_points dut (.*);

   always #4 clock = ~clock;

   function automatic logic [63:0] isqrt(logic [127:0] a);
      logic [63:0] q;
      logic [63:0] c;
      q = 0;
      for (int b = 63; b >= 0; b--) begin
         c = q | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= a) q = c;
      end
      return q;
   endfunction

   function automatic circle_type fit_circle(triple_type t);
      circle_type r;
      longint x1, y1, x2, y2, x3, y3, dx12, dy12, dx23, dy23, dx31, dy31, det, d;
      longint bb, cc, nx, ny, qx, qy;
      logic [127:0] prod;
      logic [63:0] rr;
      x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
      dx12 = x1 - x2; dy12 = y1 - y2; dx23 = x2 - x3; dy23 = y2 - y3;
      det = dx12 * dy23 - dx23 * dy12;
      r = '{0, 0, 0, 1, 0};
      if (det == 0) return r;
      r.col = 0;
      bb = x1*x1 + y1*y1 - x2*x2 - y2*y2;
      cc = x2*x2 + y2*y2 - x3*x3 - y3*y3;
      d = 2 * det;
      nx = bb * dy23 - cc * dy12;
      ny = cc * dx12 - bb * dx23;
      qx = nx / d;
      qy = ny / d;
      if (qx > 64'sd2147483647) begin qx = 64'sd2147483647; r.clip = 1; end
      if (qx < -64'sd2147483648) begin qx = -64'sd2147483648; r.clip = 1; end
      if (qy > 64'sd2147483647) begin qy = 64'sd2147483647; r.clip = 1; end
      if (qy < -64'sd2147483648) begin qy = -64'sd2147483648; r.clip = 1; end
      r.cx = qx[31:0];
      r.cy = qy[31:0];
      dx31 = x3 - x1; dy31 = y3 - y1;
      prod = 128'(dx12*dx12 + dy12*dy12) * 128'(dx23*dx23 + dy23*dy23)
             * 128'(dx31*dx31 + dy31*dy31);
      prod = prod << (2 * cctp_pkg::RADIUS_FRAC_BITS_DEF);
      rr = isqrt(prod) / 64'(d < 0 ? -d : d);
      if (rr > 64'h0000_000F_FFFF_FFFF) begin rr = 64'h0000_000F_FFFF_FFFF; r.clip = 1; end
      r.rad = rr[cctp_pkg::RADIUS_W-1:0];
      return r;
   endfunction

   function automatic logic [9:0] rc();
      case ($urandom_range(0, 5))
         0: return 10'd0;
         1: return 10'd1023;
         2: return 10'($urandom_range(0, 7));
         default: return 10'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_circles.insert(expected_circles.size(),
                                    fit_circle('{req_first_x, req_first_y, req_second_x,
                                                 req_second_y, req_third_x, req_third_y}));
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 0;
            end else if (pending.size() > 0) begin
               triple_type t;
               t = pending.pop_front();
               req_valid <= 1;
               req_first_x <= t.x1; req_first_y <= t.y1;
               req_second_x <= t.x2; req_second_y <= t.y2;
               req_third_x <= t.x3; req_third_y <= t.y3;
               if (!calm && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 8);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_circles.size() == 0) begin
               $display("%0t: unexpected beat, actual %0d %0d %0d", $time, rsp_center_x,
                        rsp_center_y, rsp_radius_q4);
               errors++;
            end else begin
               circle_type e;
               e = expected_circles.pop_front();
               if (rsp_center_x !== e.cx) begin
                  $display("%0t: center_x expected %0d actual %0d", $time, e.cx, rsp_center_x);
                  errors++;
               end
               if (rsp_center_y !== e.cy) begin
                  $display("%0t: center_y expected %0d actual %0d", $time, e.cy, rsp_center_y);
                  errors++;
               end
               if (rsp_radius_q4 !== e.rad) begin
                  $display("%0t: radius_q4 expected %0d actual %0d", $time, e.rad,
                           rsp_radius_q4);
                  errors++;
               end
               if (rsp_collinear !== e.col) begin
                  $display("%0t: collinear expected %0b actual %0b", $time, e.col,
                           rsp_collinear);
                  errors++;
               end
               if (rsp_clipped !== e.clip) begin
                  $display("%0t: clipped expected %0b actual %0b", $time, e.clip, rsp_clipped);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_gap <= $urandom_range(0, 7);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      triple_type t;
      // corners, collinear cases, coincident points, huge and tiny circles
      pending.insert(pending.size(), '{0, 0, 0, 0, 0, 0});
      pending.insert(pending.size(), '{1023, 1023, 1023, 1023, 1023, 1023});
      pending.insert(pending.size(), '{0, 0, 1023, 1023, 512, 512});
      pending.insert(pending.size(), '{0, 0, 1023, 0, 0, 1023});
      pending.insert(pending.size(), '{1023, 1023, 0, 1023, 1023, 0});
      pending.insert(pending.size(), '{0, 0, 1023, 1023, 0, 1023});
      pending.insert(pending.size(), '{0, 0, 1, 0, 0, 1});
      pending.insert(pending.size(), '{0, 0, 1023, 1, 1022, 1});
      pending.insert(pending.size(), '{0, 0, 1023, 0, 1022, 1});
      pending.insert(pending.size(), '{0, 1023, 1023, 0, 1022, 0});
      pending.insert(pending.size(), '{5, 5, 5, 5, 100, 7});
      pending.insert(pending.size(), '{10, 10, 20, 20, 10, 10});
      pending.insert(pending.size(), '{0, 0, 1, 1, 1023, 1022});
      pending.insert(pending.size(), '{341, 682, 682, 341, 1023, 0});
      pending.insert(pending.size(), '{1023, 0, 0, 1023, 1, 1023});
      pending.insert(pending.size(), '{0, 512, 1023, 511, 512, 1023});
      for (int i = 0; i < 1400; i++) begin
         t = '{rc(), rc(), rc(), rc(), rc(), rc()};
         case ($urandom_range(0, 7))
            0: begin t.x2 = t.x1; t.y2 = t.y1; end
            1: begin t.x3 = 10'(2 * t.x2 - t.x1); t.y3 = 10'(2 * t.y2 - t.y1); end
            2: begin t.x3 = 10'(t.x2 + 1); t.y3 = 10'(t.y2 + ($urandom_range(0, 1))); end
            default: ;
         endcase
         pending.insert(pending.size(), t);
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      while (pending.size() >= 150) @(posedge clock);
      calm = 1;
      while (pending.size() != 0 || req_valid || expected_circles.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_circles.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      wait (idle_cycles >= 20000);
      $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cctp_pkg.sv
hw/rtl/cctp_front.sv
hw/rtl/cctp_queue.sv
hw/rtl/cctp_back.sv
hw/rtl/circumcircle_three_points.sv
test/testbench.sv
